### rtl/core/ipl4ck_pkg.sv
// Shared types, constants and the end-around-carry adder for the IPv4/L4 checksum engine.
`default_nettype none

package ipl4ck_pkg;

  // Request carried on the packet channel
  typedef struct packed {
    logic [15:0] data_word;
    logic        last_word;
  } in_req_t;

  // Request carried on the result channel
  typedef struct packed {
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
    logic [1:0]  l4_kind;
    logic [1:0]  status;
  } out_req_t;

  // Per-packet totals handed from the accumulator to the finish stage
  typedef struct packed {
    logic [15:0] header_sum;
    logic [15:0] segment_sum;
    logic [3:0]  header_words;
    logic [15:0] total_bytes;
    logic [7:0]  proto_byte;
    logic [15:0] words;
  } snap_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TCP  = 2'd1;
  localparam logic [1:0] KIND_UDP  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // Segment word index of the L4 check field
  localparam logic [15:0] TCP_CHECK_WORD = 16'd8;
  localparam logic [15:0] UDP_CHECK_WORD = 16'd3;

  // Header word positions
  localparam logic [15:0] IHL_IDX        = 16'd0;
  localparam logic [15:0] TOTLEN_IDX     = 16'd1;
  localparam logic [15:0] PROTO_IDX      = 16'd4;
  localparam logic [15:0] HDR_CHECK_IDX  = 16'd5;
  localparam logic [15:0] ADDR_FIRST_IDX = 16'd6;
  localparam logic [15:0] ADDR_LAST_IDX  = 16'd9;

  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [4:0]  HLEN_DEFAULT   = 5'd10;
  localparam logic [15:0] WORD_COUNT_MAX = 16'hffff;
  localparam logic [15:0] CK_ALL_ONES    = 16'hffff;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

### rtl/core/ipl4ck_accum.sv
// Input register and per-packet running sums of the IPv4/L4 checksum engine.
`default_nettype none

module ipl4ck_accum
  import ipl4ck_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pkt_valid,
  output logic         pkt_stall,
  input  wire in_req_t pkt,
  output logic         snap_valid,
  input  wire logic    snap_stall,
  output snap_t        snap
);

  logic        a_valid;
  in_req_t     a_req;
  logic        a_adv;
  logic        a_load;

  logic [15:0] word_count, word_count_next;
  logic [15:0] header_sum, header_sum_next;
  logic [15:0] segment_sum, segment_sum_next;
  logic [3:0]  header_words, header_words_next;
  logic [15:0] total_bytes, total_bytes_next;
  logic [7:0]  proto_byte, proto_byte_next;

  logic [4:0]  hlen;
  logic        in_header;
  logic [16:0] off;
  logic        in_seg;
  logic        odd_tail;
  logic [15:0] seg_idx;
  logic [15:0] seg_word;
  logic [15:0] w;

  // A last word needs the finish stage free; other words advance at once
  assign a_adv      = a_valid && (!a_req.last_word || !snap_stall);
  assign pkt_stall  = a_valid && !a_adv;
  assign a_load     = pkt_valid && !pkt_stall;
  assign snap_valid = a_valid && a_req.last_word;
  assign w          = a_req.data_word;

  always_comb begin
    header_words_next = (word_count == IHL_IDX)    ? w[11:8] : header_words;
    total_bytes_next  = (word_count == TOTLEN_IDX) ? w       : total_bytes;
    proto_byte_next   = (word_count == PROTO_IDX)  ? w[7:0]  : proto_byte;

    hlen      = (header_words_next >= MIN_IHL) ? {header_words_next, 1'b0} : HLEN_DEFAULT;
    in_header = word_count < {11'd0, hlen};
    off       = {word_count, 1'b0};
    in_seg    = off < {1'b0, total_bytes_next};
    odd_tail  = (off + 17'd1) == {1'b0, total_bytes_next};
    seg_idx   = word_count - {11'd0, hlen};

    seg_word = odd_tail ? {w[15:8], 8'h00} : w;
    if ((proto_byte_next == PROTO_TCP && seg_idx == TCP_CHECK_WORD) ||
        (proto_byte_next == PROTO_UDP && seg_idx == UDP_CHECK_WORD)) begin
      seg_word = '0;
    end

    header_sum_next  = header_sum;
    segment_sum_next = segment_sum;
    word_count_next  = word_count;
    if (word_count != WORD_COUNT_MAX) begin
      if (in_header) begin
        if (word_count != HDR_CHECK_IDX) begin
          header_sum_next = oc_add(header_sum, w);
        end
        if (word_count >= ADDR_FIRST_IDX && word_count <= ADDR_LAST_IDX) begin
          segment_sum_next = oc_add(segment_sum, w);
        end
      end else if (in_seg) begin
        segment_sum_next = oc_add(segment_sum, seg_word);
      end
      word_count_next = word_count + 16'd1;
    end

    snap.header_sum   = header_sum_next;
    snap.segment_sum  = segment_sum_next;
    snap.header_words = header_words_next;
    snap.total_bytes  = total_bytes_next;
    snap.proto_byte   = proto_byte_next;
    snap.words        = word_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_req <= pkt;
    end
  end

  // Clear all packet state after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count   <= '0;
      header_sum   <= '0;
      segment_sum  <= '0;
      header_words <= '0;
      total_bytes  <= '0;
      proto_byte   <= '0;
    end else if (a_adv) begin
      if (a_req.last_word) begin
        word_count   <= '0;
        header_sum   <= '0;
        segment_sum  <= '0;
        header_words <= '0;
        total_bytes  <= '0;
        proto_byte   <= '0;
      end else begin
        word_count   <= word_count_next;
        header_sum   <= header_sum_next;
        segment_sum  <= segment_sum_next;
        header_words <= header_words_next;
        total_bytes  <= total_bytes_next;
        proto_byte   <= proto_byte_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (a_adv && a_req.last_word) |=> (word_count == '0 && header_sum == '0 &&
                                    segment_sum == '0))
    else $error("packet state not cleared after last word");
`endif

endmodule

`default_nettype wire

### rtl/core/ipl4ck_finish.sv
// Finish stage: holds packet totals, forms checksums and status, drives the result register.
`default_nettype none

module ipl4ck_finish
  import ipl4ck_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  snap_valid,
  output logic       snap_stall,
  input  wire snap_t snap,
  output logic       res_valid,
  input  wire logic  res_stall,
  output out_req_t   res
);

  logic        f_valid;
  snap_t       f;
  logic        f_adv;
  logic        f_load;

  logic [5:0]  hbytes;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic [15:0] s1;
  logic [15:0] s2;
  logic [15:0] l4;
  out_req_t    res_next;

  assign f_adv      = f_valid && (!res_valid || !res_stall);
  assign snap_stall = f_valid && !f_adv;
  assign f_load     = snap_valid && !snap_stall;

  always_comb begin
    hbytes = {f.header_words, 2'b00};

    unique case (f.proto_byte)
      PROTO_TCP: kind = KIND_TCP;
      PROTO_UDP: kind = KIND_UDP;
      default:   kind = KIND_NONE;
    endcase

    priority if (f.words < 16'd2) begin
      status = ST_TRUNCATED;
    end else if (f.header_words < MIN_IHL || f.total_bytes < {10'd0, hbytes}) begin
      status = ST_BAD_LEN;
    end else if ({f.words, 1'b0} < {1'b0, f.total_bytes}) begin
      status = ST_TRUNCATED;
    end else begin
      status = ST_OK;
    end

    if (status == ST_BAD_LEN) begin
      kind = KIND_NONE;
    end

    // Fold in the pseudo header: protocol and L4 length
    s1 = oc_add(f.segment_sum, {8'd0, f.proto_byte});
    s2 = oc_add(s1, f.total_bytes - {10'd0, hbytes});
    l4 = ~s2;
    if (kind == KIND_NONE) begin
      l4 = '0;
    end else if (kind == KIND_UDP && l4 == '0) begin
      l4 = CK_ALL_ONES;
    end

    res_next.ip_checksum = ~f.header_sum;
    res_next.l4_checksum = l4;
    res_next.l4_kind     = kind;
    res_next.status      = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_load) begin
      f_valid <= 1'b1;
    end else if (f_adv) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_load) begin
      f <= snap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (f_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_hold_totals: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_adv) |=> (f_valid && $stable(f)))
    else $error("pending packet totals lost or changed");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.l4_kind == KIND_NONE) |-> (res.l4_checksum == '0))
    else $error("L4 checksum nonzero without L4 protocol");

  a_bad_len_kind: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_BAD_LEN) |-> (res.l4_kind == KIND_NONE))
    else $error("bad header lengths reported with L4 protocol");
`endif

endmodule

`default_nettype wire

### rtl/core/ipv4_l4_checksum_engine.sv
// Top level of the IPv4 header and TCP/UDP checksum engine.
//
//   channel | dir | handshake              | request
//   --------+-----+------------------------+-------------------------------------------
//   pkt     | in  | pkt_valid / pkt_stall  | data_word (16), last_word (1)
//   res     | out | res_valid / res_stall  | ip_checksum, l4_checksum, l4_kind, status
//
// One packet word is taken every cycle unless pkt_stall is high; the running sums
// use one end-around-carry add per word in the accumulator, behind a one-word input
// register. After its last word is accepted, a result passes through the input
// register, the packet-totals register and the result register.
// Reset (rst, synchronous) empties all three registers and clears the packet state.
// A stalled result holds in its register while the totals register and the input
// register keep filling; pkt_stall rises only when a last word finds both full.
`default_nettype none

module ipv4_l4_checksum_engine
  import ipl4ck_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pkt_valid,
  output logic         pkt_stall,
  input  wire in_req_t pkt,
  output logic         res_valid,
  input  wire logic    res_stall,
  output out_req_t     res
);

  // Packet totals travel from the accumulator to the finish stage on the last word
  logic  snap_valid;
  logic  snap_stall;
  snap_t snap;

  // Register each word and advance the header and segment sums
  ipl4ck_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .pkt_valid  (pkt_valid),
    .pkt_stall  (pkt_stall),
    .pkt        (pkt),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .snap       (snap)
  );

  // Add the pseudo header, complement, and hold the result until taken
  ipl4ck_finish u_finish (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap_stall (snap_stall),
    .snap       (snap),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule

`default_nettype wire

### tb/sv/ipv4_l4_checksum_engine_tb.sv
// Self-checking testbench for the IPv4 header and TCP/UDP checksum engine.
module ipv4_l4_checksum_engine_tb;
  import ipl4ck_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_WORDS = 1300;

  // Packet checksum predictor plus the queue of results still owed by the block.
  class ipl4_scoreboard;
    logic [15:0] word_count;
    logic [15:0] header_sum;
    logic [15:0] segment_sum;
    logic [3:0]  header_words;
    logic [15:0] total_bytes;
    logic [7:0]  proto_byte;
    out_req_t    checksum_q[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned n_tcp, n_udp, n_trunc, n_badlen;

    function new();
      clear_packet();
      mismatches = 0;
      results_checked = 0;
      n_tcp = 0;
      n_udp = 0;
      n_trunc = 0;
      n_badlen = 0;
    endfunction

    function void clear_packet();
      word_count = '0;
      header_sum = '0;
      segment_sum = '0;
      header_words = '0;
      total_bytes = '0;
      proto_byte = '0;
    endfunction

    // End-around-carry add: fold the carry out of bit 15 back into bit 0.
    function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
      bit [31:0] s;
      s = 32'(a) + 32'(b);
      s = (s & 32'h0000ffff) + (s >> 16);
      return s[15:0];
    endfunction

    function int unsigned pending();
      return checksum_q.size();
    endfunction

    // Fold one accepted word into the running sums; a last word queues its result.
    function void note_word(in_req_t req);
      logic [15:0] w, v, s, l4;
      logic [1:0]  kind, status;
      int unsigned idx, hlen, off, seg, words, hbytes;
      out_req_t    exp_res;
      w = req.data_word;
      idx = word_count;
      if (idx == IHL_IDX) header_words = w[11:8];
      if (idx == TOTLEN_IDX) total_bytes = w;
      if (idx == PROTO_IDX) proto_byte = w[7:0];
      hlen = (header_words >= MIN_IHL) ? int'(header_words) * 2 : int'(HLEN_DEFAULT);
      if (idx < WORD_COUNT_MAX) begin
        if (idx < hlen) begin
          if (idx != HDR_CHECK_IDX) header_sum = ones_add(header_sum, w);
          if (idx >= ADDR_FIRST_IDX && idx <= ADDR_LAST_IDX)
            segment_sum = ones_add(segment_sum, w);
        end else begin
          off = idx * 2;
          if (off < total_bytes) begin
            v = w;
            seg = idx - hlen;
            if (off + 1 == total_bytes) v = v & 16'hff00;
            if ((proto_byte == PROTO_TCP && seg == TCP_CHECK_WORD) ||
                (proto_byte == PROTO_UDP && seg == UDP_CHECK_WORD))
              v = '0;
            segment_sum = ones_add(segment_sum, v);
          end
        end
        word_count = word_count + 16'd1;
      end
      if (!req.last_word) return;

      words = word_count;
      hbytes = int'(header_words) * 4;
      kind = KIND_NONE;
      if (proto_byte == PROTO_TCP) kind = KIND_TCP;
      else if (proto_byte == PROTO_UDP) kind = KIND_UDP;
      if (words < 2) status = ST_TRUNCATED;
      else if (header_words < MIN_IHL || total_bytes < hbytes) status = ST_BAD_LEN;
      else if (words * 2 < total_bytes) status = ST_TRUNCATED;
      else status = ST_OK;
      if (status == ST_BAD_LEN) kind = KIND_NONE;
      l4 = '0;
      if (kind != KIND_NONE) begin
        s = ones_add(segment_sum, {8'd0, proto_byte});
        s = ones_add(s, 16'(int'(total_bytes) - hbytes));
        l4 = ~s;
        if (kind == KIND_UDP && l4 == '0) l4 = CK_ALL_ONES;
      end
      exp_res.ip_checksum = ~header_sum;
      exp_res.l4_checksum = l4;
      exp_res.l4_kind = kind;
      exp_res.status = status;
      checksum_q.push_back(exp_res);
      if (kind == KIND_TCP) n_tcp++;
      if (kind == KIND_UDP) n_udp++;
      if (status == ST_TRUNCATED) n_trunc++;
      if (status == ST_BAD_LEN) n_badlen++;
      clear_packet();
    endfunction

    // Compare one accepted result with the oldest expected one.
    function void check_result(out_req_t got);
      out_req_t exp_res;
      if (checksum_q.size() == 0) begin
        $error("unexpected result: ip_checksum %h l4_checksum %h l4_kind %0d status %0d",
               got.ip_checksum, got.l4_checksum, got.l4_kind, got.status);
        mismatches++;
        return;
      end
      exp_res = checksum_q.pop_front();
      results_checked++;
      if (got.ip_checksum !== exp_res.ip_checksum) begin
        $error("ip_checksum: expected %h, got %h", exp_res.ip_checksum, got.ip_checksum);
        mismatches++;
      end
      if (got.l4_checksum !== exp_res.l4_checksum) begin
        $error("l4_checksum: expected %h, got %h", exp_res.l4_checksum, got.l4_checksum);
        mismatches++;
      end
      if (got.l4_kind !== exp_res.l4_kind) begin
        $error("l4_kind: expected %0d, got %0d", exp_res.l4_kind, got.l4_kind);
        mismatches++;
      end
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     pkt_valid = 1'b0;
  logic     pkt_stall;
  in_req_t  pkt = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  out_req_t res;

  ipl4_scoreboard sb;
  logic [15:0]    packet_words[$];
  int unsigned    words_sent = 0;
  int unsigned    packets_sent = 0;
  int unsigned    cycle_count = 0;
  int unsigned    stall_left = 0;
  int unsigned    rx_roll;
  bit             tx_quiet = 1'b0;
  bit             rx_quiet = 1'b0;

  ipv4_l4_checksum_engine dut (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sample both handshakes at the edge; values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst) begin
      if (pkt_valid && !pkt_stall) sb.note_word(pkt);
      if (res_valid && !res_stall) sb.check_result(res);
    end
  end

  // Pace the result side: hold each stall decision for a random run of cycles,
  // mostly short, now and then long enough to back up the whole pipeline.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_quiet || rx_roll < 60) begin
        res_stall <= 1'b0;
        stall_left <= $urandom_range(0, 5);
      end else if (rx_roll < 95) begin
        res_stall <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        res_stall <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // Pick the idle gap ahead of the next word: mostly none, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (tx_quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Fill the packet buffer with random words, then plant the header fields
  // that fall inside the packet.
  function automatic void build_packet(int unsigned ihl, int unsigned total,
                                       int unsigned proto, int unsigned n_words);
    int unsigned i;
    packet_words.delete();
    for (i = 0; i < n_words; i++) packet_words.push_back(16'($urandom));
    if (n_words > IHL_IDX) packet_words[IHL_IDX][15:8] = {4'h4, 4'(ihl)};
    if (n_words > TOTLEN_IDX) packet_words[TOTLEN_IDX] = 16'(total);
    if (n_words > PROTO_IDX) packet_words[PROTO_IDX][7:0] = 8'(proto);
  endfunction

  // Offer one word and hold it until the block takes it. Valid stays high
  // afterwards so the next word can follow back to back.
  task automatic send_word(input logic [15:0] w, input logic last, input int unsigned gap);
    in_req_t req;
    req.data_word = w;
    req.last_word = last;
    if (gap != 0) begin
      pkt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_valid <= 1'b1;
    pkt <= req;
    do @(posedge clk); while (pkt_stall);
    words_sent++;
  endtask

  task automatic send_packet();
    int unsigned i;
    for (i = 0; i < packet_words.size(); i++)
      send_word(packet_words[i], i == packet_words.size() - 1, pick_gap());
    packets_sent++;
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic wait_drain();
    pkt_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    int unsigned i;
    // Packet ends before the length field arrives.
    build_packet(5, 20, PROTO_TCP, 1);
    send_packet();
    // IHL of zero: header is taken as ten words, status bad length.
    build_packet(0, 20, PROTO_UDP, 3);
    send_packet();
    // IHL just below the minimum on an otherwise sane TCP packet.
    build_packet(4, 40, PROTO_TCP, 20);
    send_packet();
    // Total length shorter than the header.
    build_packet(5, 16, PROTO_UDP, 10);
    send_packet();
    // Largest header with an empty segment.
    build_packet(15, 60, PROTO_TCP, 30);
    send_packet();
    // Odd TCP length, followed by padding words past the total length.
    build_packet(5, 41, PROTO_TCP, 24);
    send_packet();
    // Odd UDP length.
    build_packet(5, 29, PROTO_UDP, 15);
    send_packet();
    // UDP sum that folds to all ones: a zero checksum goes out as all ones.
    build_packet(5, 28, PROTO_UDP, 14);
    for (i = ADDR_FIRST_IDX; i < 14; i++) packet_words[i] = '0;
    packet_words[10] = 16'hffe6;
    packet_words[13] = 16'hbeef;
    send_packet();
    // Same folding on TCP: zero stays zero; the check field is ignored.
    build_packet(5, 40, PROTO_TCP, 20);
    for (i = ADDR_FIRST_IDX; i < 20; i++) packet_words[i] = '0;
    packet_words[10] = 16'hffe5;
    packet_words[18] = 16'h1234;
    send_packet();
    // Protocol that is neither TCP nor UDP.
    build_packet(5, 28, 1, 14);
    send_packet();
    // Truncated TCP segment.
    build_packet(5, 100, PROTO_TCP, 25);
    send_packet();
    // All-ones and all-zeros packets.
    build_packet(15, 16'hffff, 8'hff, 30);
    for (i = 0; i < 30; i++) packet_words[i] = 16'hffff;
    send_packet();
    build_packet(0, 0, 0, 10);
    for (i = 0; i < 10; i++) packet_words[i] = '0;
    send_packet();
  endtask

  task automatic run_random();
    int unsigned start_words, roll, ihl, total, proto, l4len, n_words, i;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
      proto = $urandom_range(0, 99);
      if (proto < 45) proto = PROTO_TCP;
      else if (proto < 85) proto = PROTO_UDP;
      else proto = $urandom_range(0, 255);
      l4len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 60);
      total = ihl * 4 + l4len;
      n_words = (total + 1) / 2;
      // Most packets are well formed; the rest are cut short, padded, carry broken
      // length fields, or are random words throughout.
      if (roll < 75) begin
        build_packet(ihl, total, proto, n_words);
      end else if (roll < 83) begin
        build_packet(ihl, total, proto, $urandom_range(1, n_words - 1));
      end else if (roll < 89) begin
        build_packet(ihl, total, proto, n_words + $urandom_range(1, 6));
      end else if (roll < 93) begin
        build_packet($urandom_range(0, 4), total, proto, $urandom_range(2, 30));
      end else if (roll < 97) begin
        build_packet(ihl, $urandom_range(0, ihl * 4 - 1), proto,
                     ihl * 2 + $urandom_range(0, 4));
      end else begin
        build_packet(ihl, total, proto, $urandom_range(1, 30));
        for (i = 0; i < packet_words.size(); i++) packet_words[i] = 16'($urandom);
      end
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 6) == 0);
      send_packet();
      if ($urandom_range(0, 49) == 0) wait_drain();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    // Hold the sender until the directed results are all back.
    wait_drain();
    run_random();
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d packets in %0d words; checked %0d results.",
             packets_sent, words_sent, sb.results_checked);
    $display("Expected mix: %0d TCP, %0d UDP, %0d truncated, %0d bad length.",
             sb.n_tcp, sb.n_udp, sb.n_trunc, sb.n_badlen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/ipl4ck_pkg.sv
rtl/core/ipl4ck_accum.sv
rtl/core/ipl4ck_finish.sv
rtl/core/ipv4_l4_checksum_engine.sv
tb/sv/ipv4_l4_checksum_engine_tb.sv
